/* src/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define SPBC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off during reset
`define SPBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked through reset too
`define SPBC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/spbc_pkg.sv */
// shared types, codes and defaults of the soft power button controller
// no dependencies
`default_nettype none

package spbc_pkg;

    localparam int ALIVE_LOSS_TICKS_DEF = 300;
    localparam int STATE_COUNT_CAP_DEF  = 10000;
    localparam int HOLD_COUNT_WIDTH_DEF = 16;

    localparam int AliveCntW = 9;
    localparam int StateCntW = 14;
    localparam int PressW    = 16;
    localparam int CfgIdxW   = 4;
    localparam int CfgDataW  = 16;

    localparam logic [CfgIdxW-1:0] CFG_CLICK_MIN  = 4'd0;
    localparam logic [CfgIdxW-1:0] CFG_CLICK_MAX  = 4'd1;
    localparam logic [CfgIdxW-1:0] CFG_SHORT      = 4'd2;
    localparam logic [CfgIdxW-1:0] CFG_MIDDLE     = 4'd3;
    localparam logic [CfgIdxW-1:0] CFG_LONG       = 4'd4;
    localparam logic [CfgIdxW-1:0] CFG_WAIT_ACK   = 4'd5;
    localparam logic [CfgIdxW-1:0] CFG_OFF_DELAY  = 4'd6;
    localparam logic [CfgIdxW-1:0] CFG_DEAD_GRACE = 4'd7;

    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_CLICK  = 3'd1;
    localparam logic [2:0] EV_SHORT  = 3'd2;
    localparam logic [2:0] EV_MIDDLE = 3'd3;
    localparam logic [2:0] EV_LONG   = 3'd4;

    localparam logic [1:0] CMD_NONE     = 2'd0;
    localparam logic [1:0] CMD_POWEROFF = 2'd1;
    localparam logic [1:0] CMD_CONFIRM  = 2'd2;
    localparam logic [1:0] CMD_CANCEL   = 2'd3;

    localparam logic [1:0] MODE_OFF     = 2'd0;
    localparam logic [1:0] MODE_ON      = 2'd1;
    localparam logic [1:0] MODE_WAITING = 2'd2;
    localparam logic [1:0] MODE_READY   = 2'd3;

    typedef struct packed {
        logic [PressW-1:0]    click_min;
        logic [PressW-1:0]    click_max;
        logic [PressW-1:0]    short_press;
        logic [PressW-1:0]    middle_press;
        logic [PressW-1:0]    long_press;
        logic [StateCntW-1:0] wait_ack;
        logic [StateCntW-1:0] off_delay;
        logic [StateCntW-1:0] dead_grace;
    } t_cfg;

    typedef struct packed {
        logic [1:0] mode;
        logic       boost;
        logic       charge;
        logic       sys_path_low;
    } t_pwr;

endpackage

`default_nettype wire

/* src/spbc_cfg.sv */
// configuration register file
// depends on spbc_pkg
`default_nettype none

module spbc_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_wr,
    input  wire logic [spbc_pkg::CfgIdxW-1:0]  i_index,
    input  wire logic [spbc_pkg::CfgDataW-1:0] i_data,
    output spbc_pkg::t_cfg                     o_cfg
);

    spbc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.click_min    <= 16'd10;
            r_cfg.click_max    <= 16'd50;
            r_cfg.short_press  <= 16'd150;
            r_cfg.middle_press <= 16'd250;
            r_cfg.long_press   <= 16'd800;
            r_cfg.wait_ack     <= 14'd500;
            r_cfg.off_delay    <= 14'd1200;
            r_cfg.dead_grace   <= 14'd200;
        end else if (i_wr) begin
            case (i_index)
                spbc_pkg::CFG_CLICK_MIN:  r_cfg.click_min    <= i_data;
                spbc_pkg::CFG_CLICK_MAX:  r_cfg.click_max    <= i_data;
                spbc_pkg::CFG_SHORT:      r_cfg.short_press  <= i_data;
                spbc_pkg::CFG_MIDDLE:     r_cfg.middle_press <= i_data;
                spbc_pkg::CFG_LONG:       r_cfg.long_press   <= i_data;
                spbc_pkg::CFG_WAIT_ACK:   r_cfg.wait_ack     <= i_data[spbc_pkg::StateCntW-1:0];
                spbc_pkg::CFG_OFF_DELAY:  r_cfg.off_delay    <= i_data[spbc_pkg::StateCntW-1:0];
                spbc_pkg::CFG_DEAD_GRACE: r_cfg.dead_grace   <= i_data[spbc_pkg::StateCntW-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* src/spbc_key.sv */
// key hold counter and press/click event decode
// depends on spbc_pkg
`default_nettype none

module spbc_key #(
    parameter int HOLD_COUNT_WIDTH = spbc_pkg::HOLD_COUNT_WIDTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_step,
    input  wire logic           i_key,
    input  spbc_pkg::t_cfg      i_cfg,
    output logic [2:0]          o_event
);

    localparam int CmpW = (HOLD_COUNT_WIDTH > spbc_pkg::PressW) ? HOLD_COUNT_WIDTH
                                                                : spbc_pkg::PressW;

    logic [HOLD_COUNT_WIDTH-1:0] r_hold;
    logic [HOLD_COUNT_WIDTH-1:0] n_hold;
    logic [CmpW-1:0]             hold_old;
    logic [CmpW-1:0]             hold_new;
    logic                        click;

    always_comb begin
        hold_old = CmpW'(r_hold);
        click    = 1'b0;
        if (i_key) begin
            n_hold = (&r_hold) ? r_hold : HOLD_COUNT_WIDTH'(r_hold + 1'b1);
        end else begin
            click  = (hold_old >= CmpW'(i_cfg.click_min)) &&
                     (hold_old <  CmpW'(i_cfg.click_max));
            n_hold = '0;
        end
        hold_new = CmpW'(n_hold);
        if (hold_new == CmpW'(i_cfg.short_press)) begin
            o_event = spbc_pkg::EV_SHORT;
        end else if (hold_new == CmpW'(i_cfg.middle_press)) begin
            o_event = spbc_pkg::EV_MIDDLE;
        end else if (hold_new == CmpW'(i_cfg.long_press)) begin
            o_event = spbc_pkg::EV_LONG;
        end else if (click) begin
            o_event = spbc_pkg::EV_CLICK;
        end else begin
            o_event = spbc_pkg::EV_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= '0;
        end else if (i_step) begin
            r_hold <= n_hold;
        end
    end

endmodule

`default_nettype wire

/* src/spbc_beat.sv */
// host heartbeat loss counter and alive flag
// depends on spbc_pkg
`default_nettype none

module spbc_beat #(
    parameter int ALIVE_LOSS_TICKS = spbc_pkg::ALIVE_LOSS_TICKS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_step,
    input  wire logic i_pin,
    output logic      o_alive
);

    localparam logic [spbc_pkg::AliveCntW-1:0] LossLimit =
        spbc_pkg::AliveCntW'(ALIVE_LOSS_TICKS);

    logic [spbc_pkg::AliveCntW-1:0] r_loss;
    logic [spbc_pkg::AliveCntW-1:0] n_loss;
    logic                           r_alive;

    always_comb begin
        o_alive = r_alive;
        if (i_pin) begin
            n_loss  = '0;
            o_alive = 1'b1;
        end else if (!(&r_loss)) begin
            n_loss = spbc_pkg::AliveCntW'(r_loss + 1'b1);
        end else begin
            n_loss = r_loss;
        end
        if (n_loss >= LossLimit) begin
            n_loss  = LossLimit;
            o_alive = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loss  <= '0;
            r_alive <= 1'b0;
        end else if (i_step) begin
            r_loss  <= n_loss;
            r_alive <= o_alive;
        end
    end

endmodule

`default_nettype wire

/* src/spbc_power.sv */
// power mode machine with per-state tick counter and enable pins
// depends on spbc_pkg
`default_nettype none

module spbc_power #(
    parameter int STATE_COUNT_CAP = spbc_pkg::STATE_COUNT_CAP_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [2:0] i_event,
    input  wire logic [1:0] i_cmd,
    input  wire logic       i_alive,
    input  spbc_pkg::t_cfg  i_cfg,
    output spbc_pkg::t_pwr  o_pwr
);

    typedef enum logic [1:0] {
        ST_OFF     = spbc_pkg::MODE_OFF,
        ST_ON      = spbc_pkg::MODE_ON,
        ST_WAITING = spbc_pkg::MODE_WAITING,
        ST_READY   = spbc_pkg::MODE_READY
    } t_mode;

    localparam logic [spbc_pkg::StateCntW-1:0] CountCap =
        spbc_pkg::StateCntW'(STATE_COUNT_CAP);

    t_mode                           r_mode;
    t_mode                           n_mode;
    logic [spbc_pkg::StateCntW-1:0]  r_cnt;
    logic [spbc_pkg::StateCntW-1:0]  n_cnt;
    logic [spbc_pkg::StateCntW-1:0]  cnt_inc;
    logic                            r_boost;
    logic                            n_boost;
    logic                            r_charge;
    logic                            n_charge;
    logic                            r_path_low;
    logic                            n_path_low;
    logic                            off_cmd;

    always_comb begin
        n_mode     = r_mode;
        n_boost    = r_boost;
        n_charge   = r_charge;
        n_path_low = r_path_low;
        cnt_inc    = (r_cnt < CountCap) ? spbc_pkg::StateCntW'(r_cnt + 1'b1) : r_cnt;
        n_cnt      = cnt_inc;
        off_cmd    = (i_cmd == spbc_pkg::CMD_POWEROFF) || (i_cmd == spbc_pkg::CMD_CONFIRM);
        case (r_mode)
            ST_OFF: begin
                n_boost    = 1'b0;
                n_charge   = 1'b0;
                n_path_low = 1'b1;
                if (i_event == spbc_pkg::EV_SHORT) begin
                    n_mode = ST_ON;
                    n_cnt  = '0;
                end
            end
            ST_ON: begin
                n_boost    = 1'b1;
                n_charge   = 1'b1;
                n_path_low = 1'b0;
                if (i_event == spbc_pkg::EV_LONG || off_cmd) begin
                    n_mode = ST_READY;
                    n_cnt  = '0;
                end else if (i_event == spbc_pkg::EV_MIDDLE) begin
                    n_mode = ST_WAITING;
                    n_cnt  = '0;
                end else if (!i_alive && cnt_inc >= i_cfg.dead_grace) begin
                    n_mode = ST_OFF;
                    n_cnt  = '0;
                end
            end
            ST_WAITING: begin
                if (i_event == spbc_pkg::EV_LONG || off_cmd) begin
                    n_mode = ST_READY;
                    n_cnt  = '0;
                end else if (i_cmd == spbc_pkg::CMD_CANCEL || cnt_inc > i_cfg.wait_ack) begin
                    n_mode = ST_ON;
                    n_cnt  = '0;
                end
            end
            ST_READY: begin
                if (cnt_inc >= i_cfg.off_delay || !i_alive) begin
                    n_mode = ST_OFF;
                    n_cnt  = '0;
                end
            end
            default: begin
                n_mode = ST_OFF;
                n_cnt  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= ST_OFF;
            r_cnt      <= '0;
            r_boost    <= 1'b0;
            r_charge   <= 1'b0;
            r_path_low <= 1'b1;
        end else if (i_step) begin
            r_mode     <= n_mode;
            r_cnt      <= n_cnt;
            r_boost    <= n_boost;
            r_charge   <= n_charge;
            r_path_low <= n_path_low;
        end
    end

    assign o_pwr.mode         = n_mode;
    assign o_pwr.boost        = n_boost;
    assign o_pwr.charge       = n_charge;
    assign o_pwr.sys_path_low = n_path_low;

endmodule

`default_nettype wire

/* src/soft_power_button_controller.sv */
// top level of the soft power button controller
// depends on spbc_pkg, spbc_cfg, spbc_key, spbc_beat, spbc_power
`default_nettype none

// One request is one 10 ms tick (key level, heartbeat pin, host command) and
// yields exactly one result. A tick is captured in an input register and
// evaluated from there into the result register once that register is free or
// being taken; a new tick is taken every clock as long as the result register
// is free or being taken, and o_in_stall rises only when a result waits and
// i_out_stall holds it. Configuration writes are always ready and take effect
// in the cycle after the write; indexes above seven are ignored and data is
// cut to the register width.
module soft_power_button_controller #(
    parameter int ALIVE_LOSS_TICKS = spbc_pkg::ALIVE_LOSS_TICKS_DEF,
    parameter int STATE_COUNT_CAP  = spbc_pkg::STATE_COUNT_CAP_DEF,
    parameter int HOLD_COUNT_WIDTH = spbc_pkg::HOLD_COUNT_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_key_active,
    input  wire logic                          i_host_alive_pin,
    input  wire logic [1:0]                    i_host_cmd,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [2:0]                         o_press_event,
    output logic [1:0]                         o_power_state,
    output logic                               o_boost_enable,
    output logic                               o_charge_enable,
    output logic                               o_sys_path_driven_low,
    output logic                               o_host_alive,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [spbc_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [spbc_pkg::CfgDataW-1:0] i_cfg_data
);

    spbc_pkg::t_cfg cfg;
    spbc_pkg::t_pwr pwr;

    logic       r_in_valid;
    logic       r_key;
    logic       r_pin;
    logic [1:0] r_cmd;
    logic       advance;
    logic       step;
    logic [2:0] event_code;
    logic       alive;

    logic       r_out_valid;
    logic [2:0] r_event;
    logic [1:0] r_state;
    logic       r_boost;
    logic       r_charge;
    logic       r_path_low;
    logic       r_alive;

    assign advance     = !r_out_valid || !i_out_stall;
    assign step        = r_in_valid && advance;
    assign o_in_stall  = r_in_valid && !advance;
    assign o_cfg_ready = 1'b1;

    spbc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    spbc_key #(
        .HOLD_COUNT_WIDTH (HOLD_COUNT_WIDTH)
    ) u_key (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_key   (r_key),
        .i_cfg   (cfg),
        .o_event (event_code)
    );

    spbc_beat #(
        .ALIVE_LOSS_TICKS (ALIVE_LOSS_TICKS)
    ) u_beat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_pin   (r_pin),
        .o_alive (alive)
    );

    spbc_power #(
        .STATE_COUNT_CAP (STATE_COUNT_CAP)
    ) u_power (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_event (event_code),
        .i_cmd   (r_cmd),
        .i_alive (alive),
        .i_cfg   (cfg),
        .o_pwr   (pwr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_key <= i_key_active;
            r_pin <= i_host_alive_pin;
            r_cmd <= i_host_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_event    <= event_code;
            r_state    <= pwr.mode;
            r_boost    <= pwr.boost;
            r_charge   <= pwr.charge;
            r_path_low <= pwr.sys_path_low;
            r_alive    <= alive;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_press_event         = r_event;
    assign o_power_state         = r_state;
    assign o_boost_enable        = r_boost;
    assign o_charge_enable       = r_charge;
    assign o_sys_path_driven_low = r_path_low;
    assign o_host_alive          = r_alive;

endmodule

`default_nettype wire

/* src/spbc_checker.sv */
// port-level checks for the soft power button controller, bound to the top
// depends on spbc_pkg, assert_macros.svh, soft_power_button_controller
`default_nettype none

`include "assert_macros.svh"

module spbc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [2:0] o_press_event,
    input wire logic [1:0] o_power_state,
    input wire logic       o_boost_enable,
    input wire logic       o_charge_enable,
    input wire logic       o_sys_path_driven_low
);

    logic pins_paired;
    logic event_known;

    assign pins_paired = (o_boost_enable == o_charge_enable) &&
                         (o_sys_path_driven_low == !o_boost_enable);
    assign event_known = (o_press_event <= spbc_pkg::EV_LONG);

    // boost and charge move together, path released exactly when they are up
    `SPBC_ASSERT_IMPL(a_pins_paired, i_clk, i_rst_n, o_out_valid, pins_paired)

    // only defined event codes leave the block
    `SPBC_ASSERT_IMPL(a_event_known, i_clk, i_rst_n, o_out_valid, event_known)

    // input side only stalls while a result is held back
    `SPBC_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)

    // held result keeps its state
    `SPBC_ASSERT_NEXT(a_hold_state, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_power_state) && $stable(o_press_event))

    // nothing valid right after reset
    `SPBC_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid)

endmodule

bind soft_power_button_controller spbc_checker u_spbc_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .o_in_stall            (o_in_stall),
    .o_out_valid           (o_out_valid),
    .i_out_stall           (i_out_stall),
    .o_press_event         (o_press_event),
    .o_power_state         (o_power_state),
    .o_boost_enable        (o_boost_enable),
    .o_charge_enable       (o_charge_enable),
    .o_sys_path_driven_low (o_sys_path_driven_low)
);

`default_nettype wire

/* test/soft_power_button_controller_tb.sv */
// self-checking testbench of the soft power button controller: random and directed
// ticks against a cycle-free predictor of keys, heartbeat and power modes
// depends on spbc_pkg and soft_power_button_controller
module soft_power_button_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic       key;
        logic       pin;
        logic [1:0] cmd;
        bit         wait_drain;
    } t_tick;

    typedef struct packed {
        logic [2:0] ev;
        logic [1:0] mode;
        logic       boost;
        logic       charge;
        logic       path_low;
        logic       alive;
    } t_tick_result;

    logic                          clk            = 1'b0;
    logic                          rst_n          = 1'b0;
    logic                          in_valid       = 1'b0;
    logic                          key_active     = 1'b0;
    logic                          host_alive_pin = 1'b0;
    logic [1:0]                    host_cmd       = spbc_pkg::CMD_NONE;
    logic                          out_stall      = 1'b0;
    logic                          cfg_valid      = 1'b0;
    logic [spbc_pkg::CfgIdxW-1:0]  cfg_index      = '0;
    logic [spbc_pkg::CfgDataW-1:0] cfg_data       = '0;

    logic       in_stall;
    logic       out_valid;
    logic [2:0] press_event;
    logic [1:0] power_state;
    logic       boost_enable;
    logic       charge_enable;
    logic       sys_path_low;
    logic       host_alive;
    logic       cfg_ready;

    // predictor state
    logic [spbc_pkg::CfgDataW-1:0]             thr [2**spbc_pkg::CfgIdxW];
    logic [spbc_pkg::HOLD_COUNT_WIDTH_DEF-1:0] hold_cnt;
    int                                        loss_cnt;
    logic                                      alive_flag;
    logic [1:0]                                pwr_mode;
    int                                        mode_ticks;
    logic                                      boost_pin;
    logic                                      charge_pin;
    logic                                      path_low;

    t_tick        pending_ticks [$];
    t_tick_result expected_results [$];
    t_tick        cur_tick;
    t_tick_result got;
    t_tick_result want;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_run     = 0;
    int ticks_sent    = 0;
    int results_seen  = 0;
    int reg_writes    = 0;
    int mismatches    = 0;

    soft_power_button_controller u_top (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_in_valid            (in_valid),
        .o_in_stall            (in_stall),
        .i_key_active          (key_active),
        .i_host_alive_pin      (host_alive_pin),
        .i_host_cmd            (host_cmd),
        .o_out_valid           (out_valid),
        .i_out_stall           (out_stall),
        .o_press_event         (press_event),
        .o_power_state         (power_state),
        .o_boost_enable        (boost_enable),
        .o_charge_enable       (charge_enable),
        .o_sys_path_driven_low (sys_path_low),
        .o_host_alive          (host_alive),
        .i_cfg_valid           (cfg_valid),
        .o_cfg_ready           (cfg_ready),
        .i_cfg_index           (cfg_index),
        .i_cfg_data            (cfg_data)
    );

    initial forever #5 clk = ~clk;

    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic void reset_model();
        thr[spbc_pkg::CFG_CLICK_MIN]  = 16'd10;
        thr[spbc_pkg::CFG_CLICK_MAX]  = 16'd50;
        thr[spbc_pkg::CFG_SHORT]      = 16'd150;
        thr[spbc_pkg::CFG_MIDDLE]     = 16'd250;
        thr[spbc_pkg::CFG_LONG]       = 16'd800;
        thr[spbc_pkg::CFG_WAIT_ACK]   = 16'd500;
        thr[spbc_pkg::CFG_OFF_DELAY]  = 16'd1200;
        thr[spbc_pkg::CFG_DEAD_GRACE] = 16'd200;
        hold_cnt   = '0;
        loss_cnt   = 0;
        alive_flag = 1'b0;
        pwr_mode   = spbc_pkg::MODE_OFF;
        mode_ticks = 0;
        boost_pin  = 1'b0;
        charge_pin = 1'b0;
        path_low   = 1'b1;
    endfunction

    function automatic void store_reg(logic [spbc_pkg::CfgIdxW-1:0] idx,
                                      logic [spbc_pkg::CfgDataW-1:0] val);
        if (idx > spbc_pkg::CFG_DEAD_GRACE)
            return;
        if (idx >= spbc_pkg::CFG_WAIT_ACK)
            thr[idx] = val & spbc_pkg::CfgDataW'((1 << spbc_pkg::StateCntW) - 1);
        else
            thr[idx] = val;
    endfunction

    function automatic void enter_mode(logic [1:0] m);
        pwr_mode   = m;
        mode_ticks = 0;
    endfunction

    function automatic t_tick_result step_power_ctl(t_tick t);
        logic [2:0] ev;
        logic       off_req;
        ev = spbc_pkg::EV_NONE;
        if (t.key) begin
            if (hold_cnt != '1)
                hold_cnt++;
        end else begin
            if (hold_cnt >= thr[spbc_pkg::CFG_CLICK_MIN]
                    && hold_cnt < thr[spbc_pkg::CFG_CLICK_MAX])
                ev = spbc_pkg::EV_CLICK;
            hold_cnt = '0;
        end
        if (hold_cnt == thr[spbc_pkg::CFG_SHORT])
            ev = spbc_pkg::EV_SHORT;
        else if (hold_cnt == thr[spbc_pkg::CFG_MIDDLE])
            ev = spbc_pkg::EV_MIDDLE;
        else if (hold_cnt == thr[spbc_pkg::CFG_LONG])
            ev = spbc_pkg::EV_LONG;

        if (t.pin) begin
            loss_cnt   = 0;
            alive_flag = 1'b1;
        end else if (loss_cnt < 511) begin
            loss_cnt++;
        end
        if (loss_cnt >= spbc_pkg::ALIVE_LOSS_TICKS_DEF) begin
            loss_cnt   = spbc_pkg::ALIVE_LOSS_TICKS_DEF;
            alive_flag = 1'b0;
        end

        if (mode_ticks < spbc_pkg::STATE_COUNT_CAP_DEF)
            mode_ticks++;
        off_req = (t.cmd == spbc_pkg::CMD_POWEROFF) || (t.cmd == spbc_pkg::CMD_CONFIRM);
        case (pwr_mode)
            spbc_pkg::MODE_OFF: begin
                boost_pin  = 1'b0;
                charge_pin = 1'b0;
                path_low   = 1'b1;
                if (ev == spbc_pkg::EV_SHORT)
                    enter_mode(spbc_pkg::MODE_ON);
            end
            spbc_pkg::MODE_WAITING: begin
                if (ev == spbc_pkg::EV_LONG || off_req)
                    enter_mode(spbc_pkg::MODE_READY);
                else if (t.cmd == spbc_pkg::CMD_CANCEL
                             || mode_ticks > thr[spbc_pkg::CFG_WAIT_ACK])
                    enter_mode(spbc_pkg::MODE_ON);
            end
            spbc_pkg::MODE_READY: begin
                if (mode_ticks >= thr[spbc_pkg::CFG_OFF_DELAY] || !alive_flag)
                    enter_mode(spbc_pkg::MODE_OFF);
            end
            default: begin
                path_low   = 1'b0;
                boost_pin  = 1'b1;
                charge_pin = 1'b1;
                if (ev == spbc_pkg::EV_LONG || off_req)
                    enter_mode(spbc_pkg::MODE_READY);
                else if (ev == spbc_pkg::EV_MIDDLE)
                    enter_mode(spbc_pkg::MODE_WAITING);
                else if (!alive_flag && mode_ticks >= thr[spbc_pkg::CFG_DEAD_GRACE])
                    enter_mode(spbc_pkg::MODE_OFF);
            end
        endcase
        return '{ev, pwr_mode, boost_pin, charge_pin, path_low, alive_flag};
    endfunction

    task automatic note_mismatch(string msg);
        if (mismatches < 10)
            $display("mismatch at result %0d: %s", results_seen, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val)
            note_mismatch($sformatf("%s expected %0d, got %0d", name, exp_val, act_val));
    endtask

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_results.push_back(step_power_ctl(cur_tick));
                ticks_sent++;
            end
            if (!in_valid || !in_stall) begin
                if (pending_ticks.size() != 0
                        && !(pending_ticks[0].wait_drain && results_seen != ticks_sent)
                        && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_tick = pending_ticks.pop_front();
                    in_valid       <= 1'b1;
                    key_active     <= cur_tick.key;
                    host_alive_pin <= cur_tick.pin;
                    host_cmd       <= cur_tick.cmd;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                got = '{press_event, power_state, boost_enable, charge_enable,
                        sys_path_low, host_alive};
                if (expected_results.size() == 0) begin
                    note_mismatch("result with no request pending");
                end else begin
                    want = expected_results.pop_front();
                    check_field("press_event", int'(want.ev), int'(got.ev));
                    check_field("power_state", int'(want.mode), int'(got.mode));
                    check_field("boost_enable", int'(want.boost), int'(got.boost));
                    check_field("charge_enable", int'(want.charge), int'(got.charge));
                    check_field("sys_path_driven_low", int'(want.path_low),
                                int'(got.path_low));
                    check_field("host_alive", int'(want.alive), int'(got.alive));
                end
                results_seen++;
                // long hold-off so the block backs up into its input
                if (results_seen % 500 == 250)
                    stall_run = $urandom_range(40, 80);
            end
            if (stall_run > 0) begin
                out_stall <= 1'b1;
                stall_run--;
            end else begin
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    task automatic add_tick(logic key, logic pin, logic [1:0] cmd, bit hold);
        t_tick t;
        t.key        = key;
        t.pin        = pin;
        t.cmd        = cmd;
        t.wait_drain = hold;
        pending_ticks.push_back(t);
    endtask

    task automatic add_ticks(logic key, logic pin, logic [1:0] cmd, int n);
        repeat (n) add_tick(key, pin, cmd, 1'b0);
    endtask

    task automatic wait_drained();
        while (pending_ticks.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [spbc_pkg::CfgIdxW-1:0] idx,
                             logic [spbc_pkg::CfgDataW-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        store_reg(idx, val);
        reg_writes++;
    endtask

    task automatic program_regs(int cmin, int cmax, int sp, int mp, int lp,
                                int wack, int roff, int grace);
        write_reg(spbc_pkg::CFG_CLICK_MIN, spbc_pkg::CfgDataW'(cmin));
        write_reg(spbc_pkg::CFG_CLICK_MAX, spbc_pkg::CfgDataW'(cmax));
        write_reg(spbc_pkg::CFG_SHORT, spbc_pkg::CfgDataW'(sp));
        write_reg(spbc_pkg::CFG_MIDDLE, spbc_pkg::CfgDataW'(mp));
        write_reg(spbc_pkg::CFG_LONG, spbc_pkg::CfgDataW'(lp));
        write_reg(spbc_pkg::CFG_WAIT_ACK, spbc_pkg::CfgDataW'(wack));
        write_reg(spbc_pkg::CFG_OFF_DELAY, spbc_pkg::CfgDataW'(roff));
        write_reg(spbc_pkg::CFG_DEAD_GRACE, spbc_pkg::CfgDataW'(grace));
    endtask

    task automatic pick_small_regs();
        program_regs($urandom_range(0, 4), $urandom_range(0, 10), $urandom_range(1, 12),
                     $urandom_range(1, 20), $urandom_range(1, 30), $urandom_range(0, 20),
                     $urandom_range(0, 20), $urandom_range(0, 20));
    endtask

    // key presses sized around the thresholds, with some key noise
    task automatic gen_ticks(int n, int low_pct);
        int   made;
        int   len;
        int   gap;
        int   i;
        logic k;
        made = 0;
        while (made < n) begin
            gap = $urandom_range(0, 3);
            case ($urandom_range(0, 4))
                0: len = $urandom_range(thr[spbc_pkg::CFG_CLICK_MIN],
                                        thr[spbc_pkg::CFG_CLICK_MAX] + 1);
                1: len = thr[spbc_pkg::CFG_SHORT] + $urandom_range(0, 2) - 1;
                2: len = thr[spbc_pkg::CFG_MIDDLE] + $urandom_range(0, 2) - 1;
                3: len = thr[spbc_pkg::CFG_LONG] + $urandom_range(0, 2) - 1;
                default: len = $urandom_range(1, 40);
            endcase
            if (len < 0)
                len = 0;
            if (len > 40)
                len = 40;
            for (i = 0; i < gap + len + 1; i++) begin
                k = (i >= gap && i < gap + len);
                if ($urandom_range(0, 99) < 3)
                    k = !k;
                add_tick(k, $urandom_range(0, 99) >= low_pct,
                         ($urandom_range(0, 23) == 0) ? 2'($urandom_range(0, 3))
                                                      : spbc_pkg::CMD_NONE,
                         made == n / 2);
                made++;
            end
        end
    endtask

    initial begin
        int idx;
        reset_model();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset thresholds: one click
        send_idle_pct = 14;
        recv_idle_pct = 72;
        add_ticks(1'b0, 1'b1, spbc_pkg::CMD_NONE, 3);
        add_ticks(1'b1, 1'b1, spbc_pkg::CMD_NONE, 12);
        add_ticks(1'b0, 1'b1, spbc_pkg::CMD_NONE, 1);
        wait_drained();

        // directed walk through every mode and the cancel and power-off commands
        program_regs(1, 4, 5, 7, 9, 3, 2, 0);
        add_ticks(1'b1, 1'b0, spbc_pkg::CMD_NONE, 6);
        add_ticks(1'b0, 1'b1, spbc_pkg::CMD_NONE, 1);
        add_ticks(1'b1, 1'b1, spbc_pkg::CMD_NONE, 2);
        add_ticks(1'b0, 1'b1, spbc_pkg::CMD_NONE, 1);
        add_ticks(1'b1, 1'b1, spbc_pkg::CMD_NONE, 7);
        add_ticks(1'b0, 1'b1, spbc_pkg::CMD_CANCEL, 1);
        add_ticks(1'b0, 1'b1, spbc_pkg::CMD_POWEROFF, 1);
        add_ticks(1'b0, 1'b1, spbc_pkg::CMD_NONE, 2);
        add_ticks(1'b1, 1'b1, spbc_pkg::CMD_NONE, 9);
        add_ticks(1'b0, 1'b1, spbc_pkg::CMD_NONE, 1);
        wait_drained();

        // random thresholds with a heartbeat loss in the middle
        pick_small_regs();
        gen_ticks(40, 5);
        gen_ticks(310, 100);
        gen_ticks(40, 5);
        wait_drained();

        // zero short threshold, equal middle and long, empty click window
        send_idle_pct = 72;
        recv_idle_pct = 14;
        program_regs(3, 2, 0, 3, 3, 0, 0, 16'hE710);
        for (idx = spbc_pkg::CFG_DEAD_GRACE + 1; idx < 2 ** spbc_pkg::CfgIdxW; idx++)
            write_reg(spbc_pkg::CfgIdxW'(idx), spbc_pkg::CfgDataW'($urandom));
        gen_ticks(60, 5);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        pick_small_regs();
        gen_ticks(60, 10);
        wait_drained();

        // wide thresholds and masked 14-bit writes
        program_regs(0, 16'hFFFF, 30, 60000, 16'hFFFF, 16'hFFFF, 50, 10000);
        add_ticks(1'b0, 1'b1, spbc_pkg::CMD_NONE, 2);
        add_ticks(1'b1, 1'b1, spbc_pkg::CMD_NONE, 40);
        add_ticks(1'b0, 1'b1, spbc_pkg::CMD_NONE, 3);
        wait_drained();

        $display("run covered %0d ticks and %0d register writes, %0d results checked",
                 ticks_sent, reg_writes, results_seen);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
